/* hdl/aas_pkg.sv */
// shared types and constants for the altitude average and setpoint block
package aas_pkg;

  localparam int OPCODE_W    = 3;
  localparam int VALUE_W     = 12;
  localparam int MEAN_W      = 12;
  localparam int PCT_W       = 10;
  localparam int SP_W        = 7;
  localparam int STEP_W      = 6;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 4;
  // (d * 100) / 1000 is the same as d / 10
  localparam int PCT_DIVISOR = 10;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(10);
  localparam logic [SP_W-1:0]   MAX_RESET  = SP_W'(100);

  // register select, taken from paddr bit 2
  localparam logic REG_SETPOINT_STEP = 1'b0;
  localparam logic REG_SETPOINT_MAX  = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SAMPLE       = 3'd0,
    OP_RAISE        = 3'd1,
    OP_LOWER        = 3'd2,
    OP_CAPTURE_REF  = 3'd3,
    OP_LOAD_REF     = 3'd4,
    OP_LOAD_SETPT   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    REF_KEEP,
    REF_CAPTURE,
    REF_LOAD
  } ref_op_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [SP_W-1:0]   max;
  } cfg_t;

  typedef struct packed {
    ref_op_t            ref_op;
    logic [VALUE_W-1:0] value;
    logic [SP_W-1:0]    setpoint;
  } item_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* hdl/altitude_average_and_setpoint.sv */
// altitude window average and setpoint: one result per request
// throughput one request per cycle while no stall holds it, set by the fully pipelined back part
// results move unless out_stall is high with out_valid; while held, the four-entry queue takes up to four requests
// rst is synchronous: ring, sum, slot, reference and setpoint go to zero
// setpoint_step resets to 10 and setpoint_max to 100
module altitude_average_and_setpoint #(
  parameter int WINDOW_LEN  = 10,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [aas_pkg::OPCODE_W-1:0]     opcode,
  input  logic [aas_pkg::VALUE_W-1:0]      value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [aas_pkg::MEAN_W-1:0]       mean_level,
  output logic signed [aas_pkg::PCT_W-1:0] altitude_percent,
  output logic [aas_pkg::SP_W-1:0]         setpoint,
  output logic signed [aas_pkg::PCT_W-1:0] altitude_error,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [aas_pkg::ADDR_W-1:0]       paddr,
  input  logic [aas_pkg::DATA_W-1:0]       pwdata,
  output logic [aas_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import aas_pkg::*;

  // running sum also has to hold the rounding offset of half a window
  localparam int SUM_W = $clog2(WINDOW_LEN * ((1 << SAMPLE_BITS) - 1) + WINDOW_LEN / 2 + 1);
  localparam int QDW   = $bits(item_ctl_t) + SUM_W;

  // configuration registers
  cfg_t cfg;
  logic cfg_wr;

  // front to queue
  logic             push;
  item_ctl_t        push_ctl;
  logic [SUM_W-1:0] push_sum;

  // queue to back
  logic [QDW-1:0]   q_rdata;
  item_ctl_t        q_ctl;
  logic [SUM_W-1:0] q_sum;
  q_stat_t          qs;
  logic             q_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // decode on the word select bit only
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step <= STEP_RESET;
      cfg.max  <= MAX_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SETPOINT_STEP: cfg.step <= pwdata[STEP_W-1:0];
        REG_SETPOINT_MAX:  cfg.max  <= pwdata[SP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SETPOINT_STEP: prdata = DATA_W'(cfg.step);
      REG_SETPOINT_MAX:  prdata = DATA_W'(cfg.max);
      default:           prdata = '0;
    endcase
  end

  // front: ring, slot, sum and setpoint update as each request is accepted, ready for the next request
  aas_front #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .value    (value),
    .cfg      (cfg),
    .q_full   (qs.full),
    .push     (push),
    .push_ctl (push_ctl),
    .push_sum (push_sum)
  );

  aas_queue #(.DW(QDW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_ctl, push_sum}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (qs)
  );

  assign {q_ctl, q_sum} = q_rdata;

  // back: mean divide, reference update, percentage divide, output register
  aas_back #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_ctl            (q_ctl),
    .q_sum            (q_sum),
    .q_empty          (qs.empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .mean_level       (mean_level),
    .altitude_percent (altitude_percent),
    .setpoint         (setpoint),
    .altitude_error   (altitude_error)
  );

`ifndef ASSERT_OFF
  // back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !qs.empty)
    else $error("queue popped while empty");

  // an accepted request is in the queue next cycle unless one left it
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (!qs.empty || $past(q_pop)))
    else $error("accepted request missing from queue");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(qs.full && qs.empty))
    else $error("queue both full and empty");
`endif

endmodule

/* hdl/aas_cdiv.sv */
// two-stage divide by a constant: reciprocal multiply, then one correction step
module aas_cdiv #(
  parameter int XW = 16,
  parameter int D  = 10
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x,
  output logic [XW-1:0] q
);

  localparam int MW = XW + 1;
  localparam int RW = XW + 8;
  localparam logic [MW-1:0] MUL = MW'((64'd1 << XW) / D);

  logic [XW+MW-1:0] prod;
  logic [XW-1:0]    x1;
  logic [XW-1:0]    q0;
  logic [RW-1:0]    rem;

  // floor estimate is exact or one short
  assign q0  = XW'(prod[XW+MW-1:XW]);
  assign rem = RW'(x1) - RW'(q0) * RW'(D);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= (XW+MW)'(x) * (XW+MW)'(MUL);
      x1   <= x;
      q    <= (rem >= RW'(D)) ? q0 + XW'(1) : q0;
    end
  end

endmodule

/* hdl/aas_queue.sv */
// short request queue between the front and back parts
module aas_queue #(
  parameter int DW = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [DW-1:0]         wdata,
  input  logic                  pop,
  output logic [DW-1:0]         rdata,
  output aas_pkg::q_stat_t      stat
);
  import aas_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign rdata      = mem[rd_ptr];
  assign stat.full  = (count == CW'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/aas_front.sv */
// front part: takes requests, updates sample ring, sum and setpoint
module aas_front #(
  parameter int WINDOW_LEN  = 10,
  parameter int SAMPLE_BITS = 12,
  parameter int SUM_W       = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [aas_pkg::OPCODE_W-1:0]  opcode,
  input  logic [aas_pkg::VALUE_W-1:0]   value,
  input  aas_pkg::cfg_t                 cfg,
  input  logic                          q_full,
  output logic                          push,
  output aas_pkg::item_ctl_t            push_ctl,
  output logic [SUM_W-1:0]              push_sum
);
  import aas_pkg::*;

  localparam int SLW = $clog2(WINDOW_LEN);

  logic [SAMPLE_BITS-1:0] ring [WINDOW_LEN];
  logic [SLW-1:0]         slot;
  logic [SUM_W-1:0]       sum;
  logic [SP_W-1:0]        desired;

  logic [SLW-1:0]         slot_next;
  logic [SUM_W-1:0]       sum_next;
  logic [SP_W-1:0]        desired_next;
  logic [SAMPLE_BITS-1:0] sample;
  logic [SP_W:0]          raised;
  ref_op_t                ref_op;
  logic                   is_sample;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign sample   = SAMPLE_BITS'(value);
  assign raised   = {1'b0, desired} + (SP_W+1)'(cfg.step);

  always_comb begin
    slot_next    = slot;
    sum_next     = sum;
    desired_next = desired;
    ref_op       = REF_KEEP;
    is_sample    = 1'b0;
    case (op_t'(opcode))
      OP_SAMPLE: begin
        is_sample = 1'b1;
        sum_next  = sum - SUM_W'(ring[slot]) + SUM_W'(sample);
        slot_next = (slot == SLW'(WINDOW_LEN - 1)) ? '0 : slot + SLW'(1);
      end
      OP_RAISE: begin
        desired_next = (raised > {1'b0, cfg.max}) ? cfg.max : raised[SP_W-1:0];
      end
      OP_LOWER: begin
        desired_next = (desired < SP_W'(cfg.step)) ? '0 : desired - SP_W'(cfg.step);
      end
      OP_CAPTURE_REF: begin
        ref_op = REF_CAPTURE;
      end
      OP_LOAD_REF: begin
        ref_op = REF_LOAD;
      end
      OP_LOAD_SETPT: begin
        desired_next = (value > VALUE_W'(cfg.max)) ? cfg.max : value[SP_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign push_ctl.ref_op   = ref_op;
  assign push_ctl.value    = value;
  assign push_ctl.setpoint = desired_next;
  assign push_sum          = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ring[i] <= '0;
      end
      slot    <= '0;
      sum     <= '0;
      desired <= '0;
    end else if (push) begin
      if (is_sample) begin
        ring[slot] <= sample;
      end
      slot    <= slot_next;
      sum     <= sum_next;
      desired <= desired_next;
    end
  end

endmodule

/* hdl/aas_back.sv */
// back part: mean, reference, percentage and error pipeline
module aas_back #(
  parameter int WINDOW_LEN  = 10,
  parameter int SAMPLE_BITS = 12,
  parameter int SUM_W       = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  aas_pkg::item_ctl_t               q_ctl,
  input  logic [SUM_W-1:0]                 q_sum,
  input  logic                             q_empty,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [aas_pkg::MEAN_W-1:0]       mean_level,
  output logic signed [aas_pkg::PCT_W-1:0] altitude_percent,
  output logic [aas_pkg::SP_W-1:0]         setpoint,
  output logic signed [aas_pkg::PCT_W-1:0] altitude_error
);
  import aas_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + 1;
  localparam int EW = PW + 1;

  logic adv;

  // stage a/b: mean divider
  logic             va, vb;
  item_ctl_t        a_ctl, b_ctl;
  logic [SUM_W-1:0] mean_q;
  logic [SB-1:0]    b_mean;

  // stage c/d/e: percentage divider
  logic             vc, vd, ve;
  logic [SB-1:0]    c_abs;
  logic             c_neg, d_neg, e_neg;
  logic [SP_W-1:0]  c_sp, d_sp, e_sp;
  logic [SB-1:0]    c_mean, d_mean, e_mean;
  logic [SB-1:0]    pct_q;

  logic [SB-1:0]        reference;
  logic [SB-1:0]        ref_next;
  logic signed [SB:0]   diff;
  logic signed [PW-1:0] pct;
  logic signed [EW-1:0] err;

  assign adv   = !(out_valid && out_stall);
  assign q_pop = adv && !q_empty;

  aas_cdiv #(.XW(SUM_W), .D(WINDOW_LEN)) u_mean_div (
    .clk (clk),
    .en  (adv),
    .x   (q_sum + SUM_W'(WINDOW_LEN / 2)),
    .q   (mean_q)
  );

  assign b_mean = SB'(mean_q);

  // capture takes the mean of this item, which a non-sample leaves unchanged
  always_comb begin
    case (b_ctl.ref_op)
      REF_CAPTURE: ref_next = b_mean;
      REF_LOAD:    ref_next = SB'(b_ctl.value);
      default:     ref_next = reference;
    endcase
  end

  assign diff = $signed({1'b0, ref_next}) - $signed({1'b0, b_mean});

  aas_cdiv #(.XW(SB), .D(PCT_DIVISOR)) u_pct_div (
    .clk (clk),
    .en  (adv),
    .x   (c_abs),
    .q   (pct_q)
  );

  assign pct = e_neg ? -$signed({1'b0, pct_q}) : $signed({1'b0, pct_q});
  assign err = $signed({{(EW-SP_W){1'b0}}, e_sp}) - EW'(pct);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ctl  <= q_ctl;
      b_ctl  <= a_ctl;
      c_abs  <= diff[SB] ? SB'(-diff) : SB'(diff);
      c_neg  <= diff[SB];
      c_sp   <= b_ctl.setpoint;
      c_mean <= b_mean;
      d_neg  <= c_neg;
      d_sp   <= c_sp;
      d_mean <= c_mean;
      e_neg  <= d_neg;
      e_sp   <= d_sp;
      e_mean <= d_mean;
      mean_level       <= MEAN_W'(e_mean);
      altitude_percent <= PCT_W'(pct);
      setpoint         <= e_sp;
      altitude_error   <= PCT_W'(err);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      ve        <= 1'b0;
      out_valid <= 1'b0;
      reference <= '0;
    end else if (adv) begin
      va        <= q_pop;
      vb        <= va;
      vc        <= vb;
      vd        <= vc;
      ve        <= vd;
      out_valid <= ve;
      if (vb) begin
        reference <= ref_next;
      end
    end
  end

endmodule

/* tb/sv/tb_altitude_average_and_setpoint.sv */
// testbench for the altitude average and setpoint block: predictor, drivers and result checks

typedef struct {
  logic [aas_pkg::MEAN_W-1:0]       mean;
  logic signed [aas_pkg::PCT_W-1:0] pct;
  logic [aas_pkg::SP_W-1:0]         sp;
  logic signed [aas_pkg::PCT_W-1:0] err;
} altitude_result_t;

class altitude_tracker;
  localparam int RING_LEN = 10;
  localparam int HALF_LEN = RING_LEN / 2;
  localparam int PCT_DIV  = 10;

  int ring [RING_LEN];
  int slot;
  int total;
  int reference;
  int desired;
  int step;
  int limit;
  int errors;
  altitude_result_t pending_results[$];

  function new();
    foreach (ring[i]) ring[i] = 0;
    slot = 0;
    total = 0;
    reference = 0;
    desired = 0;
    step = 10;
    limit = 100;
    errors = 0;
  endfunction

  function void set_limits(int new_step, int new_limit);
    step = new_step;
    limit = new_limit;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function int window_mean();
    return (total + HALF_LEN) / RING_LEN;
  endfunction

  // advance the state by one accepted request and queue what it should show
  function void note_request(logic [aas_pkg::OPCODE_W-1:0] op,
                             logic [aas_pkg::VALUE_W-1:0] val);
    altitude_result_t r;
    int mean_now;
    int pct;
    int err;
    case (op)
      aas_pkg::OP_SAMPLE: begin
        total = total - ring[slot] + int'(val);
        ring[slot] = int'(val);
        slot = (slot == RING_LEN - 1) ? 0 : slot + 1;
      end
      aas_pkg::OP_RAISE: begin
        desired = desired + step;
        if (desired > limit) desired = limit;
      end
      aas_pkg::OP_LOWER: begin
        desired = (desired < step) ? 0 : desired - step;
      end
      aas_pkg::OP_CAPTURE_REF: reference = window_mean();
      aas_pkg::OP_LOAD_REF:    reference = int'(val);
      aas_pkg::OP_LOAD_SETPT:  desired = (int'(val) > limit) ? limit : int'(val);
      default: ;
    endcase
    mean_now = window_mean();
    // integer divide truncates toward zero
    pct = (reference - mean_now) / PCT_DIV;
    err = desired - pct;
    r.mean = aas_pkg::MEAN_W'(mean_now);
    r.pct  = aas_pkg::PCT_W'(pct);
    r.sp   = aas_pkg::SP_W'(desired);
    r.err  = aas_pkg::PCT_W'(err);
    pending_results.push_back(r);
  endfunction

  function void check_result(logic [aas_pkg::MEAN_W-1:0] mean,
                             logic signed [aas_pkg::PCT_W-1:0] pct,
                             logic [aas_pkg::SP_W-1:0] sp,
                             logic signed [aas_pkg::PCT_W-1:0] err);
    altitude_result_t e;
    if (pending_results.size() == 0) begin
      $error("unexpected result: mean_level %0d setpoint %0d", mean, sp);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (e.mean !== mean) begin
      $error("mean_level expected %0d actual %0d", e.mean, mean);
      errors++;
    end
    if (e.pct !== pct) begin
      $error("altitude_percent expected %0d actual %0d", e.pct, pct);
      errors++;
    end
    if (e.sp !== sp) begin
      $error("setpoint expected %0d actual %0d", e.sp, sp);
      errors++;
    end
    if (e.err !== err) begin
      $error("altitude_error expected %0d actual %0d", e.err, err);
      errors++;
    end
  endfunction
endclass

module tb_altitude_average_and_setpoint;
  import aas_pkg::*;

  // opcodes the block does not define, they must leave all state alone
  localparam logic [OPCODE_W-1:0] OP_SPARE_LOW  = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HIGH = 3'd7;

  localparam logic [VALUE_W-1:0] VALUE_TOP = '1;

  // extra cycles after the last expected result, for margin
  localparam int DRAIN_CYCLES = 10;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [OPCODE_W-1:0]        opcode = OP_SAMPLE;
  logic [VALUE_W-1:0]         value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [MEAN_W-1:0]          mean_level;
  logic signed [PCT_W-1:0]    altitude_percent;
  logic [SP_W-1:0]            setpoint;
  logic signed [PCT_W-1:0]    altitude_error;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  // set during one phase so that neither side idles at all
  bit no_idling = 1'b0;
  int bus_errors = 0;

  altitude_tracker tracker = new();

  altitude_average_and_setpoint uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .value            (value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .mean_level       (mean_level),
    .altitude_percent (altitude_percent),
    .setpoint         (setpoint),
    .altitude_error   (altitude_error),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // result side: check on every accepted result, then pick the next stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_result(mean_level, altitude_percent, setpoint, altitude_error);
    end
    out_stall <= no_idling ? 1'b0 : ($urandom_range(99) < 20);
  end

  // one request: optional idle cycles, then hold it until the block takes it
  task send_request(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val);
    while (!no_idling && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= val;
    do @(posedge clk); while (in_stall);
    tracker.note_request(op, val);
  endtask

  // write one register, then read it back in the next transfer
  task write_register(input logic reg_sel, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // back-to-back read of the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== data) begin
      $error("prdata expected %0d actual %0d", data, prdata);
      bus_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // stop sending and let every outstanding result come back
  task drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task send_random(input int count);
    int k;
    int pick;
    logic [OPCODE_W-1:0] op;
    logic [VALUE_W-1:0]  val;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      // samples dominate so the window keeps turning over
      if (pick < 50)      op = OP_SAMPLE;
      else if (pick < 58) op = OP_RAISE;
      else if (pick < 66) op = OP_LOWER;
      else if (pick < 74) op = OP_CAPTURE_REF;
      else if (pick < 82) op = OP_LOAD_REF;
      else if (pick < 94) op = OP_LOAD_SETPT;
      else if (pick < 97) op = OP_SPARE_LOW;
      else                op = OP_SPARE_HIGH;
      case ($urandom_range(9))
        0:       val = '0;
        1:       val = VALUE_TOP;
        2:       val = VALUE_W'($urandom_range(140));  // near the setpoint range
        default: val = VALUE_W'($urandom);
      endcase
      send_request(op, val);
    end
  endtask

  // one setting of both registers followed by random traffic
  task run_phase(input int step, input int limit, input int count, input bit steady);
    drain();
    write_register(REG_SETPOINT_STEP, DATA_W'(step));
    write_register(REG_SETPOINT_MAX, DATA_W'(limit));
    tracker.set_limits(step, limit);
    no_idling = steady;
    send_random(count);
    no_idling = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under the reset setting: step 10, limit 100
    // fill the window with full-scale samples
    repeat (10) send_request(OP_SAMPLE, VALUE_TOP);
    send_request(OP_CAPTURE_REF, 12'h000);     // reference from the mean before the item
    send_request(OP_LOAD_REF, 12'h000);        // largest negative percentage
    send_request(OP_LOAD_SETPT, VALUE_TOP);    // load above the limit saturates
    send_request(OP_RAISE, 12'h000);           // raise past the limit
    send_request(OP_SAMPLE, 12'h000);
    send_request(OP_LOAD_REF, VALUE_TOP);      // large positive percentage
    send_request(OP_LOWER, 12'h000);
    send_request(OP_LOAD_SETPT, 12'd5);
    send_request(OP_LOWER, 12'h000);           // lower below zero clamps
    send_request(OP_LOWER, 12'h000);
    send_request(OP_SPARE_LOW, VALUE_TOP);     // undefined opcodes change nothing
    send_request(OP_SPARE_HIGH, 12'haaa);
    send_request(OP_LOAD_SETPT, 12'h555);
    send_request(OP_CAPTURE_REF, 12'hfff);

    // register settings including both extremes, one phase with no idling
    run_phase(0, 127, 150, 1'b0);    // zero step, widest limit
    run_phase(63, 0, 150, 1'b0);     // setpoint above a lowered limit
    run_phase(1, 100, 150, 1'b1);
    run_phase(50, 60, 150, 1'b0);
    run_phase(63, 127, 150, 1'b0);   // error can exceed its width here
    run_phase($urandom_range(63), $urandom_range(127), 150, 1'b0);
    run_phase($urandom_range(63), $urandom_range(127), 150, 1'b0);
    drain();

    if (tracker.errors + bus_errors == 0) begin
      $display("tb_altitude_average_and_setpoint: clean");
    end else begin
      $display("tb_altitude_average_and_setpoint: errors");
    end
    $finish;
  end

  // watchdog for a hung handshake or a lost result
  initial begin
    #2000000;
    $display("tb_altitude_average_and_setpoint: errors");
    $finish;
  end

endmodule
